[rtl/fbpa_pkg.sv]
// Shared types, codes and widths of the fixed block pool allocator.
package fbpa_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned COUNT_W   = 9;
  localparam int unsigned INDEX_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    MODE_ALLOC      = 2'd0,
    MODE_FREE_INDEX = 2'd1,
    MODE_FREE_ADDR  = 2'd2,
    MODE_CLEAR      = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ITEM_SIZE  = 2'd0,
    CFG_BASE_ADDR  = 2'd1,
    CFG_POOL_COUNT = 2'd2
  } cfg_idx_e;

  localparam logic [SIZE_W-1:0]  RST_ITEM_SIZE  = 16'd16;
  localparam logic [DATA_W-1:0]  RST_BASE_ADDR  = 32'd0;
  localparam logic [COUNT_W-1:0] RST_POOL_COUNT = 9'd256;

endpackage

[rtl/fbpa_div.sv]
// Restoring divider, one quotient bit per cycle, for the address to index mapping.
module fbpa_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [fbpa_pkg::DATA_W-1:0]       dividend_i,
  input  logic [fbpa_pkg::SIZE_W-1:0]       divisor_i,
  output logic                              done_o,
  output logic [fbpa_pkg::DATA_W-1:0]       quotient_o
);

  localparam int unsigned STEPS = fbpa_pkg::DATA_W;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic [fbpa_pkg::SIZE_W-1:0] rem_q;
  logic [fbpa_pkg::SIZE_W-1:0] divisor_q;
  logic [fbpa_pkg::DATA_W-1:0] quo_q;
  logic [CNT_W-1:0]            cnt_q;
  logic                        run_q;
  logic                        done_q;

  logic [fbpa_pkg::SIZE_W:0] trial;
  logic [fbpa_pkg::SIZE_W:0] diff;
  logic                      ge;

  // Bring down the next dividend bit and try to subtract the divisor.
  always_comb begin
    trial = {rem_q, quo_q[fbpa_pkg::DATA_W-1]};
    diff  = trial - {1'b0, divisor_q};
    ge    = (trial >= {1'b0, divisor_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= '0;
      quo_q     <= dividend_i;
      divisor_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= ge ? diff[fbpa_pkg::SIZE_W-1:0] : trial[fbpa_pkg::SIZE_W-1:0];
      quo_q <= {quo_q[fbpa_pkg::DATA_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/fixed_block_pool_allocator_core.sv]
// Top level of the fixed block pool allocator: free stack memory, sequencer and registers.
//
// A command is a transaction taken at a rising edge where start is high and busy is low.
// mode_i selects allocate, free by index, free by address or clear. Each command gives
// exactly one result, shown for one cycle with done_o high; the receiver cannot stall it,
// so results are never held back and never dropped.
// Free by index, clear, an allocate from an empty pool and a free by address below the base
// give their result in the cycle after the accepting edge. A successful allocate first
// reads the free stack synchronously, then forms the address by a multiply and add in
// S_ALLOC; any other free by address starts the bit-serial divider, waits in S_DIV for its
// quotient, then checks and pushes. busy is high while a multi-cycle command runs, so no
// new command is taken until an allocate or a free by address has given its result.
// Configuration writes (item size, base address, pool count) take effect at once. They are
// to be made by the user only while the block is idle; the block itself does not enforce
// this. Writing the pool count refills the free stack. The free stack lives in one memory
// with a synchronous read. Entries below a low-water mark of the stack top have not been
// written since the last refill and read as their own position, so a refill needs no memory
// write and there is no clearing pass after reset. Reset loads item size 16, base address 0
// and a pool count of 256, clamped to the built depth, with every block free.
module fixed_block_pool_allocator_core #(
  parameter int unsigned POOL_DEPTH = 256,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fbpa_pkg::DATA_W-1:0]         cfg_data_i,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          mode_i,
  input  logic [fbpa_pkg::INDEX_W-1:0]        free_index_i,
  input  logic [fbpa_pkg::DATA_W-1:0]         free_address_i,
  output logic                                done_o,
  output logic [1:0]                          status_o,
  output logic [fbpa_pkg::INDEX_W-1:0]        pool_index_o,
  output logic [fbpa_pkg::DATA_W-1:0]         block_address_o,
  output logic [fbpa_pkg::COUNT_W-1:0]        free_count_o
);

  localparam int unsigned CW = fbpa_pkg::COUNT_W;
  localparam int unsigned IW = fbpa_pkg::INDEX_W;
  localparam int unsigned DW = fbpa_pkg::DATA_W;
  localparam int unsigned SW = fbpa_pkg::SIZE_W;

  localparam int unsigned PTR_W = $clog2(POOL_DEPTH);
  localparam logic [63:0] MASK64 = ~64'd0 >> (64 - ADDR_WIDTH);
  localparam logic [fbpa_pkg::DATA_W-1:0] ADDR_MASK = MASK64[fbpa_pkg::DATA_W-1:0];
  localparam logic [16:0] DEPTH_17 = 17'(POOL_DEPTH);
  localparam logic [fbpa_pkg::COUNT_W-1:0] RST_COUNT =
      (int'(fbpa_pkg::RST_POOL_COUNT) > POOL_DEPTH) ?
      CW'(POOL_DEPTH) : fbpa_pkg::RST_POOL_COUNT;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ALLOC = 3'b010,
    S_DIV   = 3'b100
  } state_e;

  // Configuration, stored already clamped to the values the datapath uses.
  logic [fbpa_pkg::SIZE_W-1:0] stride_q;
  logic [DW-1:0]               base_q;
  logic [CW-1:0]               count_q;
  logic [CW-1:0]               new_count;
  logic                        cfg_refill;

  // Sequencer and stack pointers.
  state_e         state_q, state_d;
  logic [CW-1:0]  top_q, top_d;
  logic [CW-1:0]  lw_q, lw_d;
  logic           fresh_q, fresh_d;
  logic [CW-1:0]  top_dec;

  // Result registers.
  logic                  done_q, done_d;
  fbpa_pkg::status_e     status_q, status_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic [DW-1:0]         addr_q, addr_d;
  logic [CW-1:0]         fcount_q, fcount_d;

  // Free stack memory.
  logic [IW-1:0]    stack_mem_q [POOL_DEPTH];
  logic [IW-1:0]    rd_data_q;
  logic             mem_we, mem_re;
  logic [PTR_W-1:0] mem_waddr, mem_raddr;
  logic [IW-1:0]    mem_wdata;

  // Push shared by both free modes.
  logic          push_req;
  logic          push_range;
  logic [IW-1:0] push_idx;

  // Divider and address datapath.
  logic          div_start;
  logic          div_done;
  logic [DW-1:0] div_quo;
  logic [DW-1:0] addr_m;
  logic [DW-1:0] addr_off;
  logic [IW-1:0] alloc_idx;
  logic [23:0]   alloc_prod;
  logic [DW-1:0] alloc_addr;

  // A pool count of zero acts as one and one beyond the built depth acts as the depth.
  always_comb begin
    if (cfg_data_i[CW-1:0] == '0) begin
      new_count = CW'(1);
    end else if ({8'd0, cfg_data_i[CW-1:0]} > DEPTH_17) begin
      new_count = CW'(POOL_DEPTH);
    end else begin
      new_count = cfg_data_i[CW-1:0];
    end
  end

  assign cfg_refill = cfg_we_i &&
                      (fbpa_pkg::cfg_idx_e'(cfg_idx_i) == fbpa_pkg::CFG_POOL_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= fbpa_pkg::RST_ITEM_SIZE;
      base_q   <= fbpa_pkg::RST_BASE_ADDR;
      count_q  <= RST_COUNT;
    end else if (cfg_we_i) begin
      unique case (fbpa_pkg::cfg_idx_e'(cfg_idx_i))
        fbpa_pkg::CFG_ITEM_SIZE: begin
          // An item size of zero acts as one.
          stride_q <= (cfg_data_i[fbpa_pkg::SIZE_W-1:0] == '0) ?
                      SW'(1) : cfg_data_i[fbpa_pkg::SIZE_W-1:0];
        end
        fbpa_pkg::CFG_BASE_ADDR: begin
          base_q <= cfg_data_i;
        end
        fbpa_pkg::CFG_POOL_COUNT: begin
          count_q <= new_count;
        end
        default: begin
        end
      endcase
    end
  end

  // The free address is cut to the address width before the range check.
  assign addr_m   = free_address_i & ADDR_MASK;
  assign addr_off = addr_m - base_q;
  assign top_dec  = top_q - CW'(1);

  // Entries below the low-water mark read as their refill value, their own position.
  assign alloc_idx  = fresh_q ? top_q[IW-1:0] : rd_data_q;
  assign alloc_prod = {16'd0, alloc_idx} * {8'd0, stride_q};
  assign alloc_addr = (base_q + {8'd0, alloc_prod}) & ADDR_MASK;

  fbpa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (addr_off),
    .divisor_i  (stride_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d    = state_q;
    top_d      = top_q;
    lw_d       = lw_q;
    fresh_d    = fresh_q;
    done_d     = 1'b0;
    status_d   = status_q;
    idx_d      = idx_q;
    addr_d     = addr_q;
    fcount_d   = fcount_q;
    mem_we     = 1'b0;
    mem_waddr  = PTR_W'(top_q);
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = PTR_W'(top_dec);
    div_start  = 1'b0;
    push_req   = 1'b0;
    push_range = 1'b0;
    push_idx   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (fbpa_pkg::mode_e'(mode_i))
            fbpa_pkg::MODE_ALLOC: begin
              if (top_q == '0) begin
                done_d   = 1'b1;
                status_d = fbpa_pkg::ST_EMPTY;
                idx_d    = '0;
                addr_d   = '0;
                fcount_d = top_q;
              end else begin
                // Pop: read the entry below the top and lower the low-water mark if the new top is below it.
                mem_re  = 1'b1;
                top_d   = top_dec;
                fresh_d = (top_dec < lw_q);
                if (top_dec < lw_q) begin
                  lw_d = top_dec;
                end
                state_d = S_ALLOC;
              end
            end
            fbpa_pkg::MODE_FREE_INDEX: begin
              push_req   = 1'b1;
              push_idx   = free_index_i;
              push_range = ({1'b0, free_index_i} >= count_q);
            end
            fbpa_pkg::MODE_FREE_ADDR: begin
              if (addr_m < base_q) begin
                done_d   = 1'b1;
                status_d = fbpa_pkg::ST_RANGE;
                idx_d    = '0;
                addr_d   = '0;
                fcount_d = top_q;
              end else begin
                div_start = 1'b1;
                state_d   = S_DIV;
              end
            end
            fbpa_pkg::MODE_CLEAR: begin
              top_d    = count_q;
              lw_d     = count_q;
              done_d   = 1'b1;
              status_d = fbpa_pkg::ST_OK;
              idx_d    = '0;
              addr_d   = '0;
              fcount_d = count_q;
            end
            default: begin
            end
          endcase
        end
      end
      S_ALLOC: begin
        done_d   = 1'b1;
        status_d = fbpa_pkg::ST_OK;
        idx_d    = alloc_idx;
        addr_d   = alloc_addr;
        fcount_d = top_q;
        state_d  = S_IDLE;
      end
      S_DIV: begin
        if (div_done) begin
          push_req   = 1'b1;
          push_idx   = div_quo[IW-1:0];
          push_range = (|div_quo[DW-1:CW]) || (div_quo[CW-1:0] >= count_q);
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // The range check comes before the full check.
    if (push_req) begin
      done_d = 1'b1;
      addr_d = '0;
      if (push_range) begin
        status_d = fbpa_pkg::ST_RANGE;
        idx_d    = '0;
        fcount_d = top_q;
      end else if (top_q >= count_q) begin
        status_d = fbpa_pkg::ST_FULL;
        idx_d    = '0;
        fcount_d = top_q;
      end else begin
        mem_we    = 1'b1;
        mem_wdata = push_idx;
        top_d     = top_q + CW'(1);
        status_d  = fbpa_pkg::ST_OK;
        idx_d     = push_idx;
        fcount_d  = top_q + CW'(1);
      end
    end

    // Writing the pool count refills the stack, as a clear does.
    if (cfg_refill) begin
      top_d = new_count;
      lw_d  = new_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      top_q   <= RST_COUNT;
      lw_q    <= RST_COUNT;
      fresh_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      lw_q    <= lw_d;
      fresh_q <= fresh_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    idx_q    <= idx_d;
    addr_q   <= addr_d;
    fcount_q <= fcount_d;
  end

  // Reads and writes never hit the same cycle, since a pop and a push are separate commands.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= stack_mem_q[mem_raddr];
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign pool_index_o    = idx_q;
  assign block_address_o = addr_q;
  assign free_count_o    = fcount_q;

endmodule
